>>> src/kmrc_pkg.sv
`timescale 1ns / 1ps
package kmrc_pkg;

  localparam int ROW_IN_W  = 8;
  localparam int POS_W     = 12;
  localparam int SYM_IN_W  = 8;
  localparam int RC_W      = 9;
  localparam int LEN_CFG_W = 13;
  localparam int CNT_W     = 13;
  localparam int COUNT_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam logic [CNT_W:0]     CAP_MAX   = 14'd8191;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_QUERY   = 1'b1;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MISMATCHES = 2'd2;

  localparam logic [RC_W-1:0]      RESET_ROW_COUNT      = 9'd1;
  localparam logic [LEN_CFG_W-1:0] RESET_ROW_LENGTH     = 13'd4096;
  localparam logic [CNT_W-1:0]     RESET_MAX_MISMATCHES = 13'd0;

  typedef struct packed {
    logic [RC_W-1:0]      row_count;
    logic [LEN_CFG_W-1:0] row_length;
    logic [CNT_W-1:0]     max_mismatches;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [ROW_IN_W-1:0] row;
    logic [POS_W-1:0]    pos;
    logic [SYM_IN_W-1:0] sym;
    logic                cmp;
    logic                last;
  } entry_t;

endpackage

>>> src/kmrc_front.sv
`timescale 1ns / 1ps
module kmrc_front import kmrc_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_LEN  = 4096
) (
  input  cfg_t                cfg,
  input  logic                op,
  input  logic [ROW_IN_W-1:0] row_index,
  input  logic [POS_W-1:0]    position,
  input  logic [SYM_IN_W-1:0] symbol,
  input  logic                last,
  output logic                keep,
  output entry_t              entry
);

  logic row_ok;
  logic pos_ok;
  logic cmp;

  assign row_ok = 32'(row_index) < MAX_ROWS;
  assign pos_ok = 32'(position) < MAX_LEN;
  assign cmp    = pos_ok && (32'(position) < 32'(cfg.row_length));

  always_comb begin
    entry.row  = row_index;
    entry.pos  = position;
    entry.sym  = symbol;
    entry.cmp  = cmp;
    entry.last = last;
    unique case (op)
      OP_WRITE: begin
        entry.kind = KIND_WRITE;
        keep       = row_ok && pos_ok;
      end
      OP_QUERY: begin
        entry.kind = KIND_QUERY;
        keep       = cmp || last;
      end
      default: begin
        entry.kind = KIND_QUERY;
        keep       = 1'b0;
      end
    endcase
  end

endmodule

>>> src/kmrc_queue.sv
`timescale 1ns / 1ps
module kmrc_queue import kmrc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t wr_entry,
  output logic   q_full,
  output logic   q_empty,
  input  logic   rd,
  output entry_t head
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign q_full  = fill == 2'd2;
  assign q_empty = fill == 2'd0;
  assign head    = slots[rd_ptr];
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      if (do_wr && !do_rd) fill <= fill + 2'd1;
      else if (do_rd && !do_wr) fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_entry;
  end

endmodule

>>> src/kmrc_back.sv
`timescale 1ns / 1ps
module kmrc_back import kmrc_pkg::*; #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_LEN     = 4096,
  parameter int SYMBOL_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  entry_t             q_head,
  output logic               q_pop,
  output logic               res_valid,
  output logic [COUNT_W-1:0] res_count,
  input  logic               res_pop
);

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LEN_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ADDR_W = ROW_W + LEN_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int RE_W   = ROW_W + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [SYMBOL_BITS-1:0] store   [DEPTH];
  logic [CNT_W-1:0]       cnt_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]    cv;

  logic [1:0]             state;
  logic [ROW_W-1:0]       idx;
  entry_t                 cur;
  logic [COUNT_W-1:0]     count;
  logic                   s1_v;
  logic [ROW_W-1:0]       s1_row;
  logic [SYMBOL_BITS-1:0] rd_sym;
  logic [CNT_W-1:0]       rd_cnt;
  logic                   rd_cv;

  logic                   start;
  logic                   st_we;
  logic [ADDR_W-1:0]      wr_addr;
  logic [SYMBOL_BITS-1:0] wr_sym;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SYMBOL_BITS-1:0] cur_sym;
  logic [RE_W-1:0]        rows_eff;
  logic [RE_W-1:0]        idx_last;
  logic [CNT_W:0]         cap_raw;
  logic [CNT_W:0]         cap;
  logic [CNT_W-1:0]       cnt_cur;
  logic [CNT_W-1:0]       cnt_new;
  logic                   mis;
  logic                   row_hit;
  logic                   finish_last;

  assign rows_eff = (32'(cfg.row_count) > MAX_ROWS) ? RE_W'(MAX_ROWS) : RE_W'(cfg.row_count);
  assign idx_last = rows_eff - 1'b1;
  assign cap_raw  = {1'b0, cfg.max_mismatches} + 1'b1;
  assign cap      = (cap_raw > CAP_MAX) ? CAP_MAX : cap_raw;

  assign wr_addr = {ROW_W'(32'(q_head.row)), LEN_W'(32'(q_head.pos))};
  assign wr_sym  = SYMBOL_BITS'(16'(q_head.sym));
  assign rd_addr = {idx, LEN_W'(32'(cur.pos))};
  assign cur_sym = SYMBOL_BITS'(16'(cur.sym));

  assign cnt_cur = rd_cv ? rd_cnt : '0;
  assign mis     = cur.cmp && (rd_sym != cur_sym);
  assign cnt_new = (mis && ({1'b0, cnt_cur} < cap)) ? cnt_cur + 1'b1 : cnt_cur;
  assign row_hit = cnt_new <= cfg.max_mismatches;

  assign finish_last = (state == S_FINISH) && cur.last;

  always_comb begin
    q_pop = 1'b0;
    start = 1'b0;
    st_we = 1'b0;
    if (state == S_IDLE && !q_empty) begin
      if (q_head.kind == KIND_WRITE) begin
        q_pop = 1'b1;
        st_we = 1'b1;
      end else if (!q_head.last || !res_valid) begin
        q_pop = 1'b1;
        start = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      s1_v      <= 1'b0;
      res_valid <= 1'b0;
      cv        <= '0;
    end else begin
      s1_v <= state == S_WALK;
      unique case (state)
        S_IDLE: begin
          if (start) state <= (rows_eff == '0) ? S_FINISH : S_WALK;
        end
        S_WALK: begin
          if ({1'b0, idx} == idx_last) state <= S_DRAIN;
        end
        S_DRAIN:  state <= S_FINISH;
        S_FINISH: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
      if (finish_last) res_valid <= 1'b1;
      else if (res_pop && res_valid) res_valid <= 1'b0;
      if (finish_last) cv <= '0;
      else if (s1_v) cv[s1_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= q_head;
      idx <= '0;
    end else if (state == S_WALK) begin
      idx <= idx + 1'b1;
    end
    if (start) count <= '0;
    else if (s1_v && cur.last && row_hit && count != COUNT_MAX) count <= count + 1'b1;
    if (finish_last) res_count <= count;
    s1_row <= idx;
    rd_cv  <= cv[idx];
  end

  always_ff @(posedge clk) begin
    if (st_we) store[wr_addr] <= wr_sym;
  end

  always_ff @(posedge clk) begin
    rd_sym <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (s1_v) cnt_mem[s1_row] <= cnt_new;
    rd_cnt <= cnt_mem[idx];
  end

endmodule

>>> src/k_mismatch_row_counter.sv
`timescale 1ns / 1ps
// a symbol write is stored when it reaches the head of the queue and the back end is idle
// a query symbol walks the rows in use one row a cycle, then drain and finish states
// (finish only, with no rows in use); a last query's result is registered in finish
// the front takes items while the two-entry queue has room
// rst clears control, counter valid bits and config to row_count 1, row_length 4096, max 0
// row store contents are left unset by reset
module k_mismatch_row_counter import kmrc_pkg::*; #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_LEN     = 4096,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 op,
  input  logic [ROW_IN_W-1:0]  row_index,
  input  logic [POS_W-1:0]     position,
  input  logic [SYM_IN_W-1:0]  symbol,
  input  logic                 last,
  output logic                 empty,
  input  logic                 pop,
  output logic [COUNT_W-1:0]   match_count,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t   cfg;
  logic   keep;
  entry_t entry;
  entry_t head;
  logic   q_empty;
  logic   q_pop;
  logic   res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count      <= RESET_ROW_COUNT;
      cfg.row_length     <= RESET_ROW_LENGTH;
      cfg.max_mismatches <= RESET_MAX_MISMATCHES;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_COUNT:      cfg.row_count      <= RC_W'(cfg_data);
        REG_ROW_LENGTH:     cfg.row_length     <= cfg_data;
        REG_MAX_MISMATCHES: cfg.max_mismatches <= cfg_data;
        default: ;
      endcase
    end
  end

  kmrc_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_LEN  (MAX_LEN)
  ) u_front (
    .cfg       (cfg),
    .op        (op),
    .row_index (row_index),
    .position  (position),
    .symbol    (symbol),
    .last      (last),
    .keep      (keep),
    .entry     (entry)
  );

  kmrc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (push && keep),
    .wr_entry (entry),
    .q_full   (full),
    .q_empty  (q_empty),
    .rd       (q_pop),
    .head     (head)
  );

  kmrc_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_count (match_count),
    .res_pop   (pop)
  );

  assign empty = !res_valid;

endmodule
